// ----- rtl/core/circle_from_three_points_defines.svh -----
// assertion macros for the circle solver
`ifndef CIRCLE_FROM_THREE_POINTS_DEFINES_SVH
`define CIRCLE_FROM_THREE_POINTS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CFTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cftp assertion failed");

// next-cycle implication, checked outside reset
`define CFTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cftp assertion failed");

// consequence in the cycle after reset
`define CFTP_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("cftp assertion failed");

`endif

// ----- rtl/core/cftp_pkg.sv -----
// widths and stage payload types of the circle solver
`timescale 1ns / 1ps
package cftp_pkg;

  localparam int CW   = 16;          // coordinate width
  localparam int DW   = CW + 1;      // point offset width
  localparam int PW   = 2 * DW;      // product width
  localparam int DETW = PW + 1;      // determinant width
  localparam int ADW  = DETW;        // magnitude of twice the determinant
  localparam int NW   = DW + PW + 2; // numerator width, signed
  localparam int QW   = NW - 1;      // center offset quotient width
  localparam int THW  = 32 + DW;     // threshold product width
  localparam int SHW  = 13;          // Q19.13 scaling of the determinant test
  localparam int RW   = 31;          // in-range offset magnitude width
  localparam int SW   = 2 * RW + 1;  // squared radius width
  localparam int CDW  = 57;          // curvature dividend width, value 2^56
  localparam int SQN  = (CDW + 1) / 2; // square root steps
  localparam int OW   = 32;          // output field width

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_COLL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] fx;
    logic signed [CW-1:0] fy;
    logic                 negx;
    logic                 negy;
    logic                 coll;
  } dhead_t;

  typedef struct packed {
    logic [OW-1:0] cx;
    logic [OW-1:0] cy;
    logic          coll;
    logic          sat;
    logic          huge;
    logic          zero;
  } chead_t;

endpackage

// ----- rtl/core/circle_from_three_points.sv -----
// circle through three points: pipelined center and curvature solver
// usage:
//   s_axis carries one transaction per point triple, tdata holds first_x,
//   first_y, middle_x, middle_y, last_x, last_y (16 bits each, Q11.4).
//   m_axis returns one transaction per triple: tdata holds center_x,
//   center_y (Q27.4) and curvature (Q8.24); tuser holds status.
//   cfg carries collinear_threshold; write it only while the pipe is empty.
// throughput: one triple per cycle unless the output stalls; the pipe
//   is fully registered: 148 register stages, among them the 52-step
//   restoring divider for the center, the 57-step divider for one over
//   the squared radius and the 29-step square root.
// reset: all stage valid bits clear, threshold returns to 1.
// stall: when the output holds a transaction that is not taken, every
//   stage holds and s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "circle_from_three_points_defines.svh"

module circle_from_three_points (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_x, first_y, middle_x, middle_y, last_x, last_y
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // center_x, center_y, curvature
  output logic [95:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic        en;
  logic [31:0] thr;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 32'd1;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // stage 0: offsets from the first point
  logic                           v0;
  logic signed [cftp_pkg::DW-1:0] bx0, by0, cx0, cy0;
  logic signed [cftp_pkg::CW-1:0] fx0, fy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx0 <= s_axis_tdata[15:0];
      fy0 <= s_axis_tdata[31:16];
      bx0 <= $signed({s_axis_tdata[47], s_axis_tdata[47:32]})
           - $signed({s_axis_tdata[15], s_axis_tdata[15:0]});
      by0 <= $signed({s_axis_tdata[63], s_axis_tdata[63:48]})
           - $signed({s_axis_tdata[31], s_axis_tdata[31:16]});
      cx0 <= $signed({s_axis_tdata[79], s_axis_tdata[79:64]})
           - $signed({s_axis_tdata[15], s_axis_tdata[15:0]});
      cy0 <= $signed({s_axis_tdata[95], s_axis_tdata[95:80]})
           - $signed({s_axis_tdata[31], s_axis_tdata[31:16]});
    end
  end

  // stage 1: products and pivot
  logic                           v1, degen1;
  logic signed [cftp_pkg::PW-1:0] pbc1, pbyc1, sbx1, sby1, scx1, scy1;
  logic        [cftp_pkg::DW-1:0] piv1, abx0, aby0;
  logic signed [cftp_pkg::DW-1:0] bx1, by1, cx1, cy1;
  logic signed [cftp_pkg::CW-1:0] fx1, fy1;

  assign abx0 = bx0[cftp_pkg::DW-1] ? (~bx0 + 1'b1) : bx0;
  assign aby0 = by0[cftp_pkg::DW-1] ? (~by0 + 1'b1) : by0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pbc1   <= bx0 * cy0;
      pbyc1  <= by0 * cx0;
      sbx1   <= bx0 * bx0;
      sby1   <= by0 * by0;
      scx1   <= cx0 * cx0;
      scy1   <= cy0 * cy0;
      piv1   <= (abx0 > aby0) ? abx0 : aby0;
      degen1 <= (bx0 == '0) && (by0 == '0);
      bx1    <= bx0;
      by1    <= by0;
      cx1    <= cx0;
      cy1    <= cy0;
      fx1    <= fx0;
      fy1    <= fy0;
    end
  end

  // stage 2: determinant, squared lengths, threshold product
  logic                             v2, degen2;
  logic signed [cftp_pkg::DETW-1:0] det2;
  logic        [cftp_pkg::PW-1:0]   b2, c2;
  logic        [cftp_pkg::THW-1:0]  rhs2;
  logic signed [cftp_pkg::DW-1:0]   bx2, by2, cx2, cy2;
  logic signed [cftp_pkg::CW-1:0]   fx2, fy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det2   <= {pbc1[cftp_pkg::PW-1], pbc1} - {pbyc1[cftp_pkg::PW-1], pbyc1};
      b2     <= sbx1 + sby1;
      c2     <= scx1 + scy1;
      rhs2   <= thr * piv1;
      degen2 <= degen1;
      bx2    <= bx1;
      by2    <= by1;
      cx2    <= cx1;
      cy2    <= cy1;
      fx2    <= fx1;
      fy2    <= fy1;
    end
  end

  // stage 3: collinear test and numerator products
  logic                               v3, coll3;
  logic signed [cftp_pkg::NW-2:0]     nxa3, nxb3, nya3, nyb3;
  logic signed [cftp_pkg::DETW-1:0]   det3;
  logic signed [cftp_pkg::CW-1:0]     fx3, fy3;
  logic        [cftp_pkg::DETW-1:0]   adet2;
  logic        [cftp_pkg::THW-1:0]    lhs2;
  logic signed [cftp_pkg::PW:0]       b2s, c2s;

  assign adet2 = det2[cftp_pkg::DETW-1] ? (~det2 + 1'b1) : det2;
  assign lhs2  = {{(cftp_pkg::THW - cftp_pkg::DETW - cftp_pkg::SHW){1'b0}},
                  adet2, {cftp_pkg::SHW{1'b0}}};
  assign b2s   = $signed({1'b0, b2});
  assign c2s   = $signed({1'b0, c2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coll3 <= degen2 || (det2 == '0) || (lhs2 < rhs2);
      nxa3  <= cy2 * b2s;
      nxb3  <= by2 * c2s;
      nya3  <= bx2 * c2s;
      nyb3  <= cx2 * b2s;
      det3  <= det2;
      fx3   <= fx2;
      fy3   <= fy2;
    end
  end

  // center offset dividers, one quotient bit per stage
  logic signed [cftp_pkg::NW-1:0]   nx3, ny3;
  logic signed [cftp_pkg::DETW:0]   dd3;

  logic                        dv  [0:cftp_pkg::QW];
  cftp_pkg::dhead_t            dh  [0:cftp_pkg::QW];
  logic [cftp_pkg::QW-1:0]     dnx [0:cftp_pkg::QW];
  logic [cftp_pkg::QW-1:0]     dny [0:cftp_pkg::QW];
  logic [cftp_pkg::QW-1:0]     dqx [0:cftp_pkg::QW];
  logic [cftp_pkg::QW-1:0]     dqy [0:cftp_pkg::QW];
  logic [cftp_pkg::ADW-1:0]    drx [0:cftp_pkg::QW];
  logic [cftp_pkg::ADW-1:0]    dry [0:cftp_pkg::QW];
  logic [cftp_pkg::ADW-1:0]    dd  [0:cftp_pkg::QW];

  assign nx3 = {nxa3[cftp_pkg::NW-2], nxa3} - {nxb3[cftp_pkg::NW-2], nxb3};
  assign ny3 = {nya3[cftp_pkg::NW-2], nya3} - {nyb3[cftp_pkg::NW-2], nyb3};
  assign dd3 = {det3, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dh[0].fx   <= fx3;
      dh[0].fy   <= fy3;
      dh[0].negx <= nx3[cftp_pkg::NW-1] ^ det3[cftp_pkg::DETW-1];
      dh[0].negy <= ny3[cftp_pkg::NW-1] ^ det3[cftp_pkg::DETW-1];
      dh[0].coll <= coll3;
      dnx[0]     <= cftp_pkg::QW'(nx3[cftp_pkg::NW-1] ? (~nx3 + 1'b1) : nx3);
      dny[0]     <= cftp_pkg::QW'(ny3[cftp_pkg::NW-1] ? (~ny3 + 1'b1) : ny3);
      dd[0]      <= cftp_pkg::ADW'(dd3[cftp_pkg::DETW] ? (~dd3 + 1'b1) : dd3);
      dqx[0]     <= '0;
      dqy[0]     <= '0;
      drx[0]     <= '0;
      dry[0]     <= '0;
    end
  end

  for (genvar i = 0; i < cftp_pkg::QW; i++) begin : g_cdiv
    logic [cftp_pkg::ADW:0] tx, ty, dz;
    logic                   gx, gy;

    assign dz = {1'b0, dd[i]};
    assign tx = {drx[i], dnx[i][cftp_pkg::QW-1-i]};
    assign ty = {dry[i], dny[i][cftp_pkg::QW-1-i]};
    assign gx = tx >= dz;
    assign gy = ty >= dz;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (en) begin
        dv[i+1] <= dv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dh[i+1]  <= dh[i];
        dnx[i+1] <= dnx[i];
        dny[i+1] <= dny[i];
        dd[i+1]  <= dd[i];
        drx[i+1] <= cftp_pkg::ADW'(gx ? (tx - dz) : tx);
        dry[i+1] <= cftp_pkg::ADW'(gy ? (ty - dz) : ty);
        dqx[i+1] <= dqx[i] | (cftp_pkg::QW'(gx) << (cftp_pkg::QW-1-i));
        dqy[i+1] <= dqy[i] | (cftp_pkg::QW'(gy) << (cftp_pkg::QW-1-i));
      end
    end
  end

  // center, clamp and radius flags
  logic signed [cftp_pkg::QW:0]   oxs, oys;
  logic signed [cftp_pkg::QW+1:0] sx, sy;
  logic                           satx, saty;
  logic [cftp_pkg::OW-1:0]        clx, cly;
  logic [cftp_pkg::QW-1:0]        qxf, qyf;
  cftp_pkg::dhead_t               dhf;

  assign qxf = dqx[cftp_pkg::QW];
  assign qyf = dqy[cftp_pkg::QW];
  assign dhf = dh[cftp_pkg::QW];
  assign oxs = dhf.negx ? -$signed({1'b0, qxf}) : $signed({1'b0, qxf});
  assign oys = dhf.negy ? -$signed({1'b0, qyf}) : $signed({1'b0, qyf});
  assign sx  = {oxs[cftp_pkg::QW], oxs} + (cftp_pkg::QW+2)'(dhf.fx);
  assign sy  = {oys[cftp_pkg::QW], oys} + (cftp_pkg::QW+2)'(dhf.fy);

  always_comb begin
    satx = 1'b0;
    clx  = sx[cftp_pkg::OW-1:0];
    if (sx > (cftp_pkg::QW+2)'(signed'(33'sh0_7FFF_FFFF))) begin
      satx = 1'b1;
      clx  = 32'h7FFF_FFFF;
    end else if (sx < (cftp_pkg::QW+2)'(signed'(33'sh1_8000_0000))) begin
      satx = 1'b1;
      clx  = 32'h8000_0000;
    end
    saty = 1'b0;
    cly  = sy[cftp_pkg::OW-1:0];
    if (sy > (cftp_pkg::QW+2)'(signed'(33'sh0_7FFF_FFFF))) begin
      saty = 1'b1;
      cly  = 32'h7FFF_FFFF;
    end else if (sy < (cftp_pkg::QW+2)'(signed'(33'sh1_8000_0000))) begin
      saty = 1'b1;
      cly  = 32'h8000_0000;
    end
  end

  logic                    e0v;
  cftp_pkg::chead_t        e0h;
  logic [cftp_pkg::RW-1:0] ax0, ay0;

  always_ff @(posedge clk) begin
    if (rst) begin
      e0v <= 1'b0;
    end else if (en) begin
      e0v <= dv[cftp_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0h.cx   <= clx;
      e0h.cy   <= cly;
      e0h.coll <= dhf.coll;
      e0h.huge <= (qxf[cftp_pkg::QW-1:cftp_pkg::RW] != '0)
               || (qyf[cftp_pkg::QW-1:cftp_pkg::RW] != '0);
      e0h.zero <= (qxf == '0) && (qyf == '0);
      e0h.sat  <= satx || saty;
      ax0      <= qxf[cftp_pkg::RW-1:0];
      ay0      <= qyf[cftp_pkg::RW-1:0];
    end
  end

  // squares of the offset
  logic                      e1v;
  cftp_pkg::chead_t          e1h;
  logic [2*cftp_pkg::RW-1:0] sqx1, sqy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1v <= 1'b0;
    end else if (en) begin
      e1v <= e0v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1h  <= e0h;
      sqx1 <= ax0 * ax0;
      sqy1 <= ay0 * ay0;
    end
  end

  // 2^56 over the squared radius, one quotient bit per stage
  logic                     cv  [0:cftp_pkg::CDW];
  cftp_pkg::chead_t         ch  [0:cftp_pkg::CDW];
  logic [cftp_pkg::SW-1:0]  cs  [0:cftp_pkg::CDW];
  logic [cftp_pkg::SW-1:0]  cr  [0:cftp_pkg::CDW];
  logic [cftp_pkg::CDW-1:0] cq  [0:cftp_pkg::CDW];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= e1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch[0] <= e1h;
      cs[0] <= {1'b0, sqx1} + {1'b0, sqy1};
      cr[0] <= '0;
      cq[0] <= '0;
    end
  end

  for (genvar i = 0; i < cftp_pkg::CDW; i++) begin : g_rdiv
    logic [cftp_pkg::SW:0] t, dz;
    logic                  g;

    assign dz = {1'b0, cs[i]};
    assign t  = {cr[i], (i == 0) ? 1'b1 : 1'b0};
    assign g  = t >= dz;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ch[i+1] <= ch[i];
        cs[i+1] <= cs[i];
        cr[i+1] <= cftp_pkg::SW'(g ? (t - dz) : t);
        cq[i+1] <= cq[i] | (cftp_pkg::CDW'(g) << (cftp_pkg::CDW-1-i));
      end
    end
  end

  // integer square root, one result bit per stage
  logic                     qv  [0:cftp_pkg::SQN];
  cftp_pkg::chead_t         qh  [0:cftp_pkg::SQN];
  logic [cftp_pkg::CDW-1:0] qr  [0:cftp_pkg::SQN];
  logic [cftp_pkg::CDW-1:0] qs  [0:cftp_pkg::SQN];

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (en) begin
      qv[0] <= cv[cftp_pkg::CDW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qh[0] <= ch[cftp_pkg::CDW];
      qr[0] <= cq[cftp_pkg::CDW];
      qs[0] <= '0;
    end
  end

  for (genvar k = 0; k < cftp_pkg::SQN; k++) begin : g_sqrt
    localparam logic [cftp_pkg::CDW-1:0] BIT =
      cftp_pkg::CDW'(1) << (cftp_pkg::CDW-1-2*k);
    logic [cftp_pkg::CDW-1:0] t;
    logic                     g;

    assign t = qs[k] + BIT;
    assign g = qr[k] >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[k+1] <= 1'b0;
      end else if (en) begin
        qv[k+1] <= qv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qh[k+1] <= qh[k];
        qr[k+1] <= g ? (qr[k] - t) : qr[k];
        qs[k+1] <= g ? ((qs[k] >> 1) + BIT) : (qs[k] >> 1);
      end
    end
  end

  // output register
  cftp_pkg::chead_t hf;

  assign hf = qh[cftp_pkg::SQN];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= qv[cftp_pkg::SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (hf.coll) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= cftp_pkg::ST_COLL;
      end else begin
        m_axis_tdata[31:0]  <= hf.cx;
        m_axis_tdata[63:32] <= hf.cy;
        if (hf.huge) begin
          m_axis_tdata[95:64] <= '0;
        end else if (hf.zero) begin
          m_axis_tdata[95:64] <= 32'hFFFF_FFFF;
        end else begin
          m_axis_tdata[95:64] <= qs[cftp_pkg::SQN][cftp_pkg::OW-1:0];
        end
        m_axis_tuser <= (hf.sat || hf.zero) ? cftp_pkg::ST_SAT : cftp_pkg::ST_OK;
      end
    end
  end

  `CFTP_ASSERT_IMP(a_coll_zero, m_axis_tvalid && (m_axis_tuser == cftp_pkg::ST_COLL), m_axis_tdata == '0)
  `CFTP_ASSERT_IMP(a_status_code, m_axis_tvalid, m_axis_tuser != 2'd3)
  `CFTP_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, $stable(qv[cftp_pkg::SQN]))
  `CFTP_ASSERT_RST(a_reset_empty, !m_axis_tvalid)

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the three-point circle solver
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT = 600000;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] curv;
    logic [1:0]  status;
  } circle_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  logic [95:0] triple_q[$];
  circle_t     circle_q[$];
  logic [31:0] thr_now = 32'd1;
  int          cycles = 0;
  int          errors = 0;
  int          checked = 0;
  int          cfg_writes = 0;
  int          send_idle;
  int          recv_stall;
  logic        hold_on = 1'b0;
  logic        hold_used = 1'b0;
  int          hold_cnt = 0;
  logic        in_taken = 1'b0;

  circle_from_three_points dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic signed [127:0] mag(input logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic circle_t solve_circle(input logic [95:0] pts, input logic [31:0] thr);
    logic signed [127:0] fx, fy, bx, by, cx, cy, det, apiv, lhs, rhs;
    logic signed [127:0] b2, c2, nx, ny, ox, oy, sx, sy, aox, aoy;
    logic [63:0] ax, ay;
    logic sat;
    circle_t r;
    fx = $signed(pts[15:0]);
    fy = $signed(pts[31:16]);
    bx = $signed(pts[47:32]) - fx;
    by = $signed(pts[63:48]) - fy;
    cx = $signed(pts[79:64]) - fx;
    cy = $signed(pts[95:80]) - fy;
    r = '{32'd0, 32'd0, 32'd0, cftp_pkg::ST_COLL};
    if (bx == 0 && by == 0) return r;
    det = bx * cy - by * cx;
    apiv = (mag(bx) > mag(by)) ? mag(bx) : mag(by);
    lhs = mag(det) <<< 13;
    rhs = $signed({96'd0, thr}) * apiv;
    if (det == 0 || lhs < rhs) return r;
    b2 = bx * bx + by * by;
    c2 = cx * cx + cy * cy;
    nx = cy * b2 - by * c2;
    ny = bx * c2 - cx * b2;
    ox = nx / (det <<< 1);
    oy = ny / (det <<< 1);
    sat = 1'b0;
    sx = ox + fx;
    sy = oy + fy;
    if (sx > $signed(128'h7FFF_FFFF)) begin
      r.cx = 32'h7FFF_FFFF; sat = 1'b1;
    end else if (sx < -$signed(128'h8000_0000)) begin
      r.cx = 32'h8000_0000; sat = 1'b1;
    end else begin
      r.cx = sx[31:0];
    end
    if (sy > $signed(128'h7FFF_FFFF)) begin
      r.cy = 32'h7FFF_FFFF; sat = 1'b1;
    end else if (sy < -$signed(128'h8000_0000)) begin
      r.cy = 32'h8000_0000; sat = 1'b1;
    end else begin
      r.cy = sy[31:0];
    end
    aox = mag(ox);
    aoy = mag(oy);
    if (aox >= $signed(128'h8000_0000) || aoy >= $signed(128'h8000_0000)) begin
      r.curv = 32'd0;
    end else begin
      ax = aox[63:0];
      ay = aoy[63:0];
      if (ax == 0 && ay == 0) begin
        r.curv = 32'hFFFF_FFFF;
        sat = 1'b1;
      end else begin
        r.curv = 32'(root64((64'd1 << 56) / (ax * ax + ay * ay)));
      end
    end
    r.status = sat ? cftp_pkg::ST_SAT : cftp_pkg::ST_OK;
    return r;
  endfunction

  function automatic logic [95:0] pack_pts(input shortint fx, fy, mx, my, lx, ly);
    return {ly, lx, my, mx, fy, fx};
  endfunction

  function automatic shortint near(input shortint base, input int span);
    return shortint'(int'(base) + $urandom_range(2 * span) - span);
  endfunction

  function automatic logic [95:0] random_triple();
    shortint fx, fy, bx, by;
    int k;
    fx = shortint'($urandom);
    fy = shortint'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: return {$urandom, $urandom, $urandom};
      4, 5, 6: return pack_pts(fx, fy, near(fx, 64), near(fy, 64), near(fx, 64), near(fy, 64));
      7: begin
        bx = shortint'($urandom_range(4000) - 2000);
        by = shortint'($urandom_range(4000) - 2000);
        k = $urandom_range(6) - 3;
        return pack_pts(fx, fy, fx + bx, fy + by, near(fx + k * bx, 2), near(fy + k * by, 2));
      end
      8: return pack_pts(fx, fy, fx, fy, shortint'($urandom), shortint'($urandom));
      default: return pack_pts(fx, fy, near(fx, 1), near(fy, 1), near(fx, 1), near(fy, 1));
    endcase
  endfunction

  // stimulus driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (triple_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tdata  <= triple_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_on && !hold_used) begin
      hold_used = 1'b1;
      hold_cnt  = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    circle_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    in_taken = s_axis_tvalid && s_axis_tready && !rst;
    if (in_taken) circle_q = {circle_q, solve_circle(s_axis_tdata, thr_now)};
    if (!rst && cfg_valid && cfg_ready) begin
      thr_now = cfg_data;
      cfg_writes++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (circle_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = circle_q.pop_front();
        checked++;
        if (m_axis_tdata[31:0] !== want.cx) begin
          $error("center_x expected %0d got %0d", $signed(want.cx), $signed(m_axis_tdata[31:0]));
          errors++;
        end
        if (m_axis_tdata[63:32] !== want.cy) begin
          $error("center_y expected %0d got %0d", $signed(want.cy), $signed(m_axis_tdata[63:32]));
          errors++;
        end
        if (m_axis_tdata[95:64] !== want.curv) begin
          $error("curvature expected %0h got %0h", want.curv, m_axis_tdata[95:64]);
          errors++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status expected %0d got %0d", want.status, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  task automatic queue_triple(input logic [95:0] t);
    triple_q = {triple_q, t};
  endtask

  task automatic drain();
    while (!(triple_q.size() == 0 && !s_axis_tvalid && circle_q.size() == 0)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] v);
    int seen;
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n, input int idle, input int stall);
    send_idle  = idle;
    recv_stall = stall;
    repeat (n) queue_triple(random_triple());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle = 0; recv_stall = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners at the reset threshold
    queue_triple(pack_pts(-32768, -32768, 32767, -32768, -32768, 32767));
    queue_triple(pack_pts(32767, 32767, -32768, 32767, 32767, -32768));
    queue_triple(pack_pts(-32768, 32767, 32767, -32768, 32767, 32767));
    queue_triple(pack_pts(0, 0, 16, 0, 0, 16));
    queue_triple(pack_pts(100, 200, 100, 200, 5, 9));
    queue_triple(pack_pts(7, 7, 7, 7, 7, 7));
    queue_triple(pack_pts(0, 0, 10, 10, 20, 20));
    queue_triple(pack_pts(0, 0, 1, 0, 0, 1));
    queue_triple(pack_pts(-1, -1, 0, -1, -1, 0));
    queue_triple(pack_pts(-32768, -32768, 32767, 32767, 32767, 32766));
    queue_triple(pack_pts(-32768, 0, 32767, 1, 32767, 0));
    queue_triple(pack_pts(0, 0, 32767, 0, -32768, 1));
    queue_triple(pack_pts(0, 0, 3000, 1, 6000, 3));
    queue_triple(pack_pts(-5, 3, 27, -40, 900, 880));
    queue_triple(pack_pts(16, 0, 0, 16, -16, 0));
    run_random(0, 0, 0);

    // zero threshold: only an exact zero determinant is collinear
    write_threshold(32'd0);
    queue_triple(pack_pts(0, 0, 10, 10, 20, 20));
    queue_triple(pack_pts(-32768, -32768, 32767, 32767, 32767, 32766));
    queue_triple(pack_pts(0, 0, 32767, 0, -32768, 1));
    run_random(200, 0, 0);

    write_threshold(32'hFFFF_FFFF);
    queue_triple(pack_pts(0, 0, 16, 0, 0, 16));
    run_random(100, 88, 0);

    write_threshold($urandom_range(20000));
    run_random(200, 0, 88);

    write_threshold(32'd1);
    run_random(200, 21, 21);

    // long output hold-off so the pipe fills and stalls its input
    write_threshold($urandom);
    hold_on = 1'b1;
    run_random(300, 0, 0);

    write_threshold(32'd65536);
    run_random(100, 21, 21);

    repeat (200) @(posedge clk);
    $display("%0d circle results checked over %0d threshold writes", checked, cfg_writes);
    $display("idling mixes: none, sender idle, receiver stall, both, long hold-off");
    if (errors == 0 && circle_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/cftp_pkg.sv
rtl/core/circle_from_three_points.sv
tb/sv/tb_top.sv
